FILE: hdl/bounded_pair_table_defines.svh
// Assertion macros shared by the bounded pair table checker.
`ifndef BOUNDED_PAIR_TABLE_DEFINES_SVH
`define BOUNDED_PAIR_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BPT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bounded_pair_table check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define BPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bounded_pair_table check failed");

`endif

FILE: hdl/bpt_pkg.sv
// Shared types and constants for the bounded pair table.
`timescale 1ns / 1ps

package bpt_pkg;

   // Fixed field widths of the request and response beats
   localparam int MODE_WIDTH   = 2;
   localparam int KEY_WIDTH    = 16;
   localparam int INDEX_WIDTH  = 4;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;

   // Parameter defaults
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 16;

   // Operation codes
   localparam logic [MODE_WIDTH-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_READ   = 2'd2;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]  mode;
      logic [KEY_WIDTH-1:0]   key;
      logic [KEY_WIDTH-1:0]   value;
      logic [INDEX_WIDTH-1:0] index;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [KEY_WIDTH-1:0]    key_out;
      logic [KEY_WIDTH-1:0]    value_out;
      logic [COUNT_WIDTH-1:0]  count;
   } rsp_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic occupied;
      logic load_new;
      logic shift;
      logic capture;
   } cell_ctrl_type;

endpackage

FILE: hdl/bounded_pair_table.sv
// Top level of the bounded pair table: sequencer, chain of cells, response register.
// An accepted request goes to the apply state, by way of the match state for an add
//   when duplicates are not allowed; rsp_valid and rsp_data are registered at the apply step.
// One operation at a time: the accept/probe/apply sequencer stalls the request side from
//   acceptance until the apply step is taken; a stalled response holds the apply step.
// Reset (synchronous): table empty, duplicates allowed, no response pending.
`timescale 1ns / 1ps

module bounded_pair_table #(
   parameter int DEPTH      = bpt_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bpt_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import bpt_pkg::*;

   // Stored width, count width, compare width, addressable cells
   localparam int SW   = (DATA_WIDTH < KEY_WIDTH) ? DATA_WIDTH : KEY_WIDTH;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;
   localparam int NA   = (DEPTH < (1 << INDEX_WIDTH)) ? DEPTH : (1 << INDEX_WIDTH);

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          allow_dup_ff, allow_dup_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          apply_go;
   logic          do_append;
   logic          do_shift;
   logic          any_hit;
   logic          out_of_range;
   logic [SW-1:0] sel_key;
   logic [SW-1:0] sel_value;
   logic [SW-1:0] bc_key;
   logic [SW-1:0] bc_value;

   cell_ctrl_type    cell_ctrl  [DEPTH];
   logic [SW-1:0]    cell_key   [DEPTH];
   logic [SW-1:0]    cell_value [DEPTH];
   logic [DEPTH-1:0] hit_vec;

   // Handshakes
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign apply_go   = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready  = 1'b1;

   // Broadcast pair, kept to the stored width
   assign bc_key       = req_ff.key[SW-1:0];
   assign bc_value     = req_ff.value[SW-1:0];
   assign any_hit      = |hit_vec;
   assign out_of_range = CMPW'(req_ff.index) >= CMPW'(count_ff);

   // Chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] Pos = CW'(i);
      logic [SW-1:0] nb_key;
      logic [SW-1:0] nb_value;

      if (i == DEPTH - 1) begin : g_last
         assign nb_key   = cell_key[i];
         assign nb_value = cell_value[i];
      end else begin : g_mid
         assign nb_key   = cell_key[i+1];
         assign nb_value = cell_value[i+1];
      end

      assign cell_ctrl[i].occupied = Pos < count_ff;
      assign cell_ctrl[i].load_new = do_append && (count_ff == Pos);
      assign cell_ctrl[i].shift    = do_shift && (CMPW'(Pos) >= CMPW'(req_ff.index));
      assign cell_ctrl[i].capture  = (state_ff == S_MATCH);

      bpt_cell #(
         .SW(SW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .new_key    (bc_key),
         .new_value  (bc_value),
         .next_key   (nb_key),
         .next_value (nb_value),
         .cell_key   (cell_key[i]),
         .cell_value (cell_value[i]),
         .hit        (hit_vec[i])
      );
   end

   // Entry select for read/remove, over the cells an index can reach
   always_comb begin
      sel_key   = '0;
      sel_value = '0;
      for (int j = 0; j < NA; j++) begin
         if (req_ff.index == INDEX_WIDTH'(j)) begin
            sel_key   = cell_key[j];
            sel_value = cell_value[j];
         end
      end
   end

   // Operation decode and response build
   always_comb begin
      do_append          = 1'b0;
      do_shift           = 1'b0;
      count_in           = count_ff;
      rsp_data_in        = rsp_data_ff;
      rsp_data_in.status = ST_OK;
      rsp_data_in.key_out   = '0;
      rsp_data_in.value_out = '0;

      case (req_ff.mode) inside
         MODE_ADD: begin
            if (!allow_dup_ff && any_hit) begin
               rsp_data_in.status = ST_DUP;
            end else if (count_ff == CW'(DEPTH)) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               do_append = apply_go;
               count_in  = count_ff + CW'(1);
            end
         end
         MODE_REMOVE, MODE_READ: begin
            if (out_of_range) begin
               rsp_data_in.status = ST_RANGE;
            end else begin
               rsp_data_in.key_out   = KEY_WIDTH'(sel_key);
               rsp_data_in.value_out = KEY_WIDTH'(sel_value);
               if (req_ff.mode == MODE_REMOVE) begin
                  do_shift = apply_go;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         default: ;
      endcase

      rsp_data_in.count = COUNT_WIDTH'(count_in);
      if (!apply_go) begin
         count_in    = count_ff;
         rsp_data_in = rsp_data_ff;
      end
   end

   // Sequencer next state, request capture, response valid, csr
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      allow_dup_in = allow_dup_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in = req_data;
               if (req_data.mode == MODE_ADD && !allow_dup_ff) begin
                  state_in = S_MATCH;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_MATCH: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (apply_go) begin
         rsp_valid_in = 1'b1;
      end
      if (csr_valid && csr_ready) begin
         allow_dup_in = csr_data;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         allow_dup_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         allow_dup_ff <= allow_dup_in;
         req_ff       <= req_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/bpt_cell.sv
// One table cell: holds a pair, takes its right neighbor on a shift, flags a match.
`timescale 1ns / 1ps

module bpt_cell #(
   parameter int SW = bpt_pkg::KEY_WIDTH
) (
   input  logic                   clock,
   input  bpt_pkg::cell_ctrl_type ctrl,
   input  logic [SW-1:0]          new_key,
   input  logic [SW-1:0]          new_value,
   input  logic [SW-1:0]          next_key,
   input  logic [SW-1:0]          next_value,
   output logic [SW-1:0]          cell_key,
   output logic [SW-1:0]          cell_value,
   output logic                   hit
);
   import bpt_pkg::*;

   logic [SW-1:0] key_ff;
   logic [SW-1:0] value_ff;
   logic          hit_ff;

   // Pair storage: append writes the broadcast pair, delete pulls from neighbor
   always_ff @(posedge clock) begin
      if (ctrl.load_new) begin
         key_ff   <= new_key;
         value_ff <= new_value;
      end else if (ctrl.shift) begin
         key_ff   <= next_key;
         value_ff <= next_value;
      end
   end

   // Duplicate probe, only live entries count
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         hit_ff <= ctrl.occupied && (key_ff == new_key) && (value_ff == new_value);
      end
   end

   assign cell_key   = key_ff;
   assign cell_value = value_ff;
   assign hit        = hit_ff;

endmodule

FILE: hdl/bpt_checker.sv
// Port-level checks for the bounded pair table, bound to the top level.
`timescale 1ns / 1ps
`include "bounded_pair_table_defines.svh"

module bpt_checker #(
   parameter int DEPTH = bpt_pkg::DEPTH_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bpt_pkg::rsp_type rsp_data
);
   import bpt_pkg::*;

   logic req_beat;
   logic rejected;
   logic pair_zero;

   assign req_beat  = req_valid && !req_stall;
   assign rejected  = (rsp_data.status == ST_DUP) || (rsp_data.status == ST_FULL) ||
                      (rsp_data.status == ST_RANGE);
   assign pair_zero = (rsp_data.key_out == '0) && (rsp_data.value_out == '0);

   // One operation at a time: taking a beat closes the request side
   `BPT_ASSERT_NEXT(a_busy_after_accept, req_beat, req_stall)

   // Rejected operations carry no pair
   `BPT_ASSERT_NOW(a_reject_zero_pair, rsp_valid && rejected, pair_zero)

   // Count never exceeds capacity
   `BPT_ASSERT_NOW(a_count_bound, rsp_valid, (DEPTH > 31) || (rsp_data.count <= DEPTH))

   // Stalled response holds
   `BPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind bounded_pair_table bpt_checker #(.DEPTH(DEPTH)) u_bpt_checker (.*);
